@@ hw/rtl/interrupt_controller_8259_lite_core_assert.svh @@
// assertion macros for the interrupt controller core
`ifndef INTERRUPT_CONTROLLER_8259_LITE_CORE_ASSERT_SVH
`define INTERRUPT_CONTROLLER_8259_LITE_CORE_ASSERT_SVH

// same-cycle implication, checked on every clock edge out of reset
`define PIC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interrupt controller core: same-cycle check failed");

// next-cycle implication
`define PIC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interrupt controller core: next-cycle check failed");

`endif

@@ hw/rtl/pic_pkg.sv @@
// shared types, command constants and bit helpers for the interrupt controller
package pic_pkg;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_ACK   = 2'd2,
        MODE_RAISE = 2'd3
    } mode_t;

    localparam logic [7:0] ICW1_FLAG      = 8'h10;
    localparam logic [7:0] OCW3_SEL_MASK  = 8'h98;
    localparam logic [7:0] OCW3_SEL_VALUE = 8'h08;
    localparam logic [7:0] EOI_FLAG       = 8'h20;
    localparam int         RR_BIT         = 1;
    localparam int         RIS_BIT        = 0;
    localparam int         SINGLE_BIT     = 1;

    localparam logic [2:0] STEP_ICW1 = 3'd1;
    localparam logic [2:0] STEP_ICW2 = 3'd2;
    localparam logic [2:0] STEP_ICW3 = 3'd3;
    localparam logic [2:0] STEP_ICW4 = 3'd4;
    localparam logic [2:0] STEP_DONE = 3'd5;

    // isolate the lowest set bit
    function automatic logic [7:0] lowest_onehot(input logic [7:0] v);
        return v & (~v + 8'd1);
    endfunction

    // index of the lowest set bit, zero when none is set
    function automatic logic [2:0] lowest_index(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ hw/rtl/interrupt_controller_8259_lite_core.sv @@
// top level of the simplified 8259-style interrupt controller
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   input   | in_valid / in_ready | mode, port, write_data, irq_line
//   output  | out_valid/out_ready | read_data, vector, vector_valid
//
// one request per cycle while in_ready is high: a request lands in the input
// register, and when it fires it updates the controller state and, for reads
// and acknowledges, loads the result register, which drives out_valid
// writes and line raises produce no result and retire without touching
// the output side; a stalled result holds only requests that need a result
// asynchronous active-low reset clears all control state and the icw words
// the input register keeps accepting while a result waits, up to one
// request deep behind the result register
module interrupt_controller_8259_lite_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic       port,
    input  logic [7:0] write_data,
    input  logic [2:0] irq_line,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic [7:0] vector,
    output logic       vector_valid
);

    // input register
    logic              s1_valid_reg;
    pic_pkg::mode_t    s1_mode_reg;
    logic              s1_port_reg;
    logic [7:0]        s1_data_reg;
    logic [2:0]        s1_line_reg;

    // controller state
    logic [7:0] mask_reg,    mask_next;
    logic [7:0] request_reg, request_next;
    logic [7:0] service_reg, service_next;
    logic [2:0] init_step_reg, init_step_next;
    logic [7:0] icw1_reg, icw1_next;
    logic [7:0] icw2_reg, icw2_next;
    logic       read_select_reg, read_select_next;

    // result register
    logic       out_valid_reg;
    logic [7:0] read_data_reg,    read_data_next;
    logic [7:0] vector_reg,       vector_next;
    logic       vector_valid_reg, vector_valid_next;

    logic       s1_has_result;
    logic       out_free;
    logic       s1_fire;
    logic       in_fire;
    logic [7:0] pending;
    logic [7:0] pend_onehot;
    logic [7:0] eoi_onehot;
    logic [2:0] step_eff;

    assign s1_has_result = (s1_mode_reg == pic_pkg::MODE_READ)
                        || (s1_mode_reg == pic_pkg::MODE_ACK);
    assign out_free      = !out_valid_reg || out_ready;
    // a write or raise never waits on the output side
    assign s1_fire       = s1_valid_reg && (!s1_has_result || out_free);
    assign in_ready      = !s1_valid_reg || s1_fire;
    assign in_fire       = in_valid && in_ready;

    assign pending     = request_reg & ~mask_reg;
    assign pend_onehot = pic_pkg::lowest_onehot(pending);
    assign eoi_onehot  = pic_pkg::lowest_onehot(service_reg);

    // in single mode icw3 is skipped
    assign step_eff = ((init_step_reg == pic_pkg::STEP_ICW3) && icw1_reg[pic_pkg::SINGLE_BIT])
                    ? pic_pkg::STEP_ICW4 : init_step_reg;

    // state update and result for the request in the input register
    always_comb
    begin
        mask_next         = mask_reg;
        request_next      = request_reg;
        service_next      = service_reg;
        init_step_next    = init_step_reg;
        icw1_next         = icw1_reg;
        icw2_next         = icw2_reg;
        read_select_next  = read_select_reg;
        read_data_next    = 8'd0;
        vector_next       = 8'd0;
        vector_valid_next = 1'b0;

        unique case (s1_mode_reg)
            pic_pkg::MODE_READ:
            begin
                if (s1_port_reg)
                begin
                    read_data_next = mask_reg;
                end
                else
                begin
                    read_data_next = read_select_reg ? service_reg : request_reg;
                end
            end
            pic_pkg::MODE_WRITE:
            begin
                if (!s1_port_reg)
                begin
                    if ((s1_data_reg & pic_pkg::ICW1_FLAG) != 8'd0)
                    begin
                        // icw1 restarts initialization, nothing else applies
                        mask_next      = 8'd0;
                        icw1_next      = s1_data_reg;
                        init_step_next = pic_pkg::STEP_ICW2;
                    end
                    else
                    begin
                        // ocw3 read select only when rr is set
                        if (((s1_data_reg & pic_pkg::OCW3_SEL_MASK) == pic_pkg::OCW3_SEL_VALUE)
                            && s1_data_reg[pic_pkg::RR_BIT])
                        begin
                            read_select_next = s1_data_reg[pic_pkg::RIS_BIT];
                        end
                        // eoi clears the lowest in-service bit
                        if ((s1_data_reg & pic_pkg::EOI_FLAG) != 8'd0)
                        begin
                            service_next = service_reg & ~eoi_onehot;
                        end
                    end
                end
                else if (step_eff < pic_pkg::STEP_DONE)
                begin
                    if (step_eff == pic_pkg::STEP_ICW1)
                    begin
                        icw1_next = s1_data_reg;
                    end
                    if (step_eff == pic_pkg::STEP_ICW2)
                    begin
                        icw2_next = s1_data_reg;
                    end
                    init_step_next = step_eff + 3'd1;
                end
                else
                begin
                    mask_next = s1_data_reg;
                end
            end
            pic_pkg::MODE_ACK:
            begin
                if (pending != 8'd0)
                begin
                    request_next      = request_reg & ~pend_onehot;
                    service_next      = service_reg | pend_onehot;
                    vector_next       = icw2_reg + {5'd0, pic_pkg::lowest_index(pending)};
                    vector_valid_next = 1'b1;
                end
            end
            pic_pkg::MODE_RAISE:
            begin
                request_next = request_reg | (8'd1 << s1_line_reg);
            end
            default:
            begin
            end
        endcase
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_mode_reg <= pic_pkg::mode_t'(mode);
            s1_port_reg <= port;
            s1_data_reg <= write_data;
            s1_line_reg <= irq_line;
        end
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg        <= 8'd0;
            request_reg     <= 8'd0;
            service_reg     <= 8'd0;
            init_step_reg   <= 3'd0;
            icw1_reg        <= 8'd0;
            icw2_reg        <= 8'd0;
            read_select_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            mask_reg        <= mask_next;
            request_reg     <= request_next;
            service_reg     <= service_next;
            init_step_reg   <= init_step_next;
            icw1_reg        <= icw1_next;
            icw2_reg        <= icw2_next;
            read_select_reg <= read_select_next;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_fire && s1_has_result;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_has_result)
        begin
            read_data_reg    <= read_data_next;
            vector_reg       <= vector_next;
            vector_valid_reg <= vector_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = read_data_reg;
    assign vector       = vector_reg;
    assign vector_valid = vector_valid_reg;

`include "interrupt_controller_8259_lite_core_assert.svh"

    // the step counter saturates at the mask stage
    `PIC_ASSERT_NOW(a_step_range, 1'b1, init_step_reg <= pic_pkg::STEP_DONE)
    // an acknowledge result never carries read data
    `PIC_ASSERT_NOW(a_ack_no_read, out_valid_reg && vector_valid_reg, read_data_reg == 8'd0)
    // a back-pressured input always has a request parked in the input register
    `PIC_ASSERT_NOW(a_ready_low, !in_ready, s1_valid_reg && s1_has_result && !out_free)
    // a granted acknowledge leaves its line in service
    `PIC_ASSERT_NEXT(a_ack_service,
        s1_fire && (s1_mode_reg == pic_pkg::MODE_ACK) && (pending != 8'd0),
        (service_reg & $past(pend_onehot)) != 8'd0)

endmodule
